### rtl/cws_pkg.sv
// ============================================================================
// cws_pkg - shared types and constants for cone-weighted smoothing
// Storage sizes, field widths, controller states and the command and status
// groups between the controller and the datapath.
// ============================================================================
package cws_pkg;

    // grid store and register limits
    localparam int MAX_WIDTH_N  = 64;
    localparam int MAX_HEIGHT_N = 64;
    localparam int CFG_W        = 7;
    localparam int COORD_W      = 6;
    localparam int ADDR_W       = 2 * COORD_W;
    localparam int STORE_DEPTH  = MAX_WIDTH_N * MAX_HEIGHT_N;

    localparam logic [CFG_W-1:0] MAX_RADIUS = 7'd64;
    localparam logic [CFG_W-1:0] MAX_WIDTH  = 7'd64;
    localparam logic [CFG_W-1:0] MAX_HEIGHT = 7'd64;

    localparam logic [CFG_W-1:0] RADIUS_RST = 7'd10;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 7'd64;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 7'd64;

    // register indexes
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // input function codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // datapath widths
    localparam int OFS_W  = 8;   // window offset / position, signed
    localparam int D2_W   = 14;  // squared distance
    localparam int R2_W   = 13;  // squared radius
    localparam int Q_W    = 32;  // scaled distance quotient
    localparam int RT_W   = 16;  // square root
    localparam int SR_W   = 18;  // square root remainder
    localparam int WT_W   = 17;  // weight, 1..65536
    localparam int SUM_W  = 37;  // weighted sum, signed
    localparam int CNT_W  = 13;  // positions counted
    localparam int OUT_W  = 24;

    localparam logic [WT_W-1:0] WEIGHT_ONE = 17'd65536;

    // iteration counts of the serial units
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] DIV_LAST  = 6'(Q_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = 6'(RT_W - 1);
    localparam logic [STEP_W-1:0] MEAN_LAST = 6'(SUM_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_SQRT,
        ST_ACC,
        ST_MINIT,
        ST_MEAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic store;
        logic start;
        logic scan;
        logic advance;
        logic div_step;
        logic sqrt_step;
        logic acc;
        logic mean_init;
        logic mean_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_grid; // current position lies in the grid
        logic live;    // inside the cone, weight above zero
        logic last;    // final position of the window
    } status_t;

endpackage

### rtl/cws_ctrl.sv
// ============================================================================
// cws_ctrl - sequencer for cone-weighted smoothing
// Walks the window, runs the serial divider and root steps, then the final
// mean division, and owns the result valid flag.
// ============================================================================
module cws_ctrl
    import cws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    func,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              load_ok;

    assign load_ok = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && func == FUNC_QUERY)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.in_grid && status.live)
                    state_next = ST_DIV;
                else if (status.last)
                    state_next = ST_MINIT;
            end
            ST_DIV:
            begin
                if (step_reg == DIV_LAST)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (step_reg == SQRT_LAST)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = status.last ? ST_MINIT : ST_SCAN;
            end
            ST_MINIT:
                state_next = ST_MEAN;
            ST_MEAN:
            begin
                if (step_reg == MEAN_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_ok)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign step_next = (state_next != state_reg) ? '0 : step_reg + 1'b1;

    // outputs
    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.store = in_valid && func == FUNC_STORE;
                cmd.start = in_valid && func == FUNC_QUERY;
            end
            ST_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.advance = !(status.in_grid && status.live);
            end
            ST_DIV:
                cmd.div_step = 1'b1;
            ST_SQRT:
                cmd.sqrt_step = 1'b1;
            ST_ACC:
            begin
                cmd.acc     = 1'b1;
                cmd.advance = 1'b1;
            end
            ST_MINIT:
                cmd.mean_init = 1'b1;
            ST_MEAN:
                cmd.mean_step = 1'b1;
            ST_DONE:
            begin
                cmd.out_load = load_ok;
                if (load_ok)
                    out_valid_next = 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

### rtl/cws_dp.sv
// ============================================================================
// cws_dp - datapath for cone-weighted smoothing
// Sample store, configuration registers, window walker, serial divider,
// serial square root, accumulator and serial mean divider.
// ============================================================================
module cws_dp
    import cws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic signed [7:0]        sample,
    input  logic [COORD_W-1:0]       col,
    input  logic [COORD_W-1:0]       row,
    input  cmd_t                     cmd,
    output status_t                  status,
    output logic signed [OUT_W-1:0]  smoothed
);

    logic [CFG_W-1:0] radius_reg, width_reg, height_reg;
    logic [CFG_W-1:0] r_c, gw_c, gh_c;

    logic [7:0] mem [STORE_DEPTH];
    logic signed [7:0] mem_q_reg;

    logic [COORD_W-1:0]     cen_col_reg, cen_row_reg;
    logic signed [OFS_W-1:0] ox_reg, oy_reg;
    logic [R2_W-1:0]        r2_reg;
    logic [D2_W-1:0]        drem_reg;
    logic [Q_W-1:0]         q_reg;
    logic [SR_W-1:0]        srem_reg;
    logic [RT_W-1:0]        root_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]       mdv_reg;
    logic [CNT_W:0]         mrem_reg;
    logic                   mneg_reg;
    logic signed [OUT_W-1:0] out_reg;

    logic signed [OFS_W-1:0] neg_r, r_m1, xr, yr, ax8, ay8;
    logic [6:0]              ax, ay;
    logic [D2_W-1:0]         d2;
    logic [D2_W:0]           dsh;
    logic [SR_W+1:0]         st, strial;
    logic [WT_W-1:0]         weight;
    logic signed [25:0]      prod;
    logic [CNT_W+1:0]        msh;
    logic signed [SUM_W:0]   mean_s;
    logic signed [OUT_W-1:0] mean_sat;
    logic [SUM_W-1:0]        sum_mag;

    // clamp registers to their legal ranges
    assign r_c  = (radius_reg == '0) ? 7'd1 : (radius_reg > MAX_RADIUS ? MAX_RADIUS : radius_reg);
    assign gw_c = (width_reg == '0) ? 7'd1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    assign gh_c = (height_reg == '0) ? 7'd1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // window geometry
    assign neg_r = 8'sd0 - $signed({1'b0, r_c});
    assign r_m1  = $signed({1'b0, r_c}) - 8'sd1;
    assign xr    = $signed({2'b00, cen_col_reg}) + ox_reg;
    assign yr    = $signed({2'b00, cen_row_reg}) + oy_reg;
    assign ax8   = ox_reg[OFS_W-1] ? (8'sd0 - ox_reg) : ox_reg;
    assign ay8   = oy_reg[OFS_W-1] ? (8'sd0 - oy_reg) : oy_reg;
    assign ax    = ax8[6:0];
    assign ay    = ay8[6:0];
    assign d2    = ({7'd0, ax} * {7'd0, ax}) + ({7'd0, ay} * {7'd0, ay});

    assign status.in_grid = !xr[OFS_W-1] && !yr[OFS_W-1]
                            && (xr[6:0] < gw_c) && (yr[6:0] < gh_c);
    assign status.live    = {1'b0, r2_reg} > d2;
    assign status.last    = (ox_reg == r_m1) && (oy_reg == r_m1);

    // sample store, row-major
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[{row, col}] <= sample;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
            mem_q_reg <= $signed(mem[{yr[COORD_W-1:0], xr[COORD_W-1:0]}]);
    end

    // serial step arithmetic
    assign dsh    = {drem_reg, 1'b0};
    assign st     = {srem_reg, q_reg[Q_W-1 -: 2]};
    assign strial = {2'b00, root_reg, 2'b01};
    assign weight = WEIGHT_ONE - {1'b0, root_reg};
    assign prod   = mem_q_reg * $signed({1'b0, weight});
    assign msh    = {mrem_reg, mdv_reg[SUM_W-1]};
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    assign mean_s = mneg_reg ? -$signed({1'b0, mdv_reg}) : $signed({1'b0, mdv_reg});
    always_comb
    begin
        if (count_reg == '0)
            mean_sat = '0;
        else if (mean_s > $signed({{(SUM_W-OUT_W+1){1'b0}}, {1'b0, {(OUT_W-1){1'b1}}}}))
            mean_sat = {1'b0, {(OUT_W-1){1'b1}}};
        else if (mean_s < $signed({{(SUM_W-OUT_W+1){1'b1}}, {1'b1, {(OUT_W-1){1'b0}}}}))
            mean_sat = {1'b1, {(OUT_W-1){1'b0}}};
        else
            mean_sat = mean_s[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cen_col_reg <= col;
            cen_row_reg <= row;
            ox_reg      <= neg_r;
            oy_reg      <= neg_r;
            sum_reg     <= '0;
            count_reg   <= '0;
            r2_reg      <= R2_W'({7'd0, r_c} * {7'd0, r_c});
        end
        if (cmd.scan)
        begin
            if (status.in_grid)
                count_reg <= count_reg + 1'b1;
            drem_reg <= d2;
            q_reg    <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.advance)
        begin
            if (ox_reg == r_m1)
            begin
                ox_reg <= neg_r;
                oy_reg <= oy_reg + 8'sd1;
            end
            else
                ox_reg <= ox_reg + 8'sd1;
        end
        if (cmd.div_step)
        begin
            if (dsh >= {2'b00, r2_reg})
            begin
                drem_reg <= D2_W'(dsh - {2'b00, r2_reg});
                q_reg    <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dsh[D2_W-1:0];
                q_reg    <= {q_reg[Q_W-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_step)
        begin
            q_reg <= {q_reg[Q_W-3:0], 2'b00};
            if (st >= strial)
            begin
                srem_reg <= SR_W'(st - strial);
                root_reg <= {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= st[SR_W-1:0];
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
        end
        if (cmd.acc)
            sum_reg <= sum_reg + SUM_W'(prod);
        if (cmd.mean_init)
        begin
            mneg_reg <= sum_reg[SUM_W-1];
            mdv_reg  <= sum_mag;
            mrem_reg <= '0;
        end
        if (cmd.mean_step)
        begin
            if (msh >= {2'b00, count_reg})
            begin
                mrem_reg <= (CNT_W+1)'(msh - {2'b00, count_reg});
                mdv_reg  <= {mdv_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                mrem_reg <= msh[CNT_W:0];
                mdv_reg  <= {mdv_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
            out_reg <= mean_sat;
    end

    assign smoothed = out_reg;

endmodule

### rtl/cone_weighted_smoothing_unit.sv
// ============================================================================
// cone_weighted_smoothing_unit - cone-weighted smoothing over a sample grid
// Stores samples in a 64x64 grid and returns, per query, the cone-weighted
// mean of the window around a position, in sample units times 65536.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | in_valid / in_stall  | func, sample, col, row
//  output   | out_valid / out_stall| smoothed
//  config   | cfg_we               | cfg_index, cfg_data
//
//  A store transaction is taken in the idle state. A query walks every
//  window position; a position outside the grid or outside the cone only
//  passes the scan; one inside both runs scan, 32 divider steps, 16 root
//  steps and accumulate. The query ends with the mean division and the
//  result load.
//  Reset clears control state and the configuration registers only; the sample store is not cleared.
//  A waiting result sits in the output register; a new store is taken while
//  it waits, and a further query stalls only at its own result load.
//
module cone_weighted_smoothing_unit
    import cws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic signed [7:0]        sample,
    input  logic [COORD_W-1:0]       col,
    input  logic [COORD_W-1:0]       row,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  smoothed
);

    cmd_t    cmd;
    status_t status;

    // sequencer: one transaction at a time, result flag kept here
    cws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // store, window walker and serial arithmetic units
    cws_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .col       (col),
        .row       (row),
        .cmd       (cmd),
        .status    (status),
        .smoothed  (smoothed)
    );

endmodule
